// File: hw/rtl/ifs_pkg.sv
// Shared types and constants for the IFS field splitter.
// No dependencies; every other file in hw/rtl refers to this package.
package ifs_pkg;

  // Separator mask: four 64-bit registers cover byte values 0 to 255.
  localparam int unsigned IFS_MASK_W    = 64;
  localparam int unsigned IFS_MASK_REGS = 4;
  localparam int unsigned IFS_CFG_IDX_W = 8;

  localparam logic [IFS_CFG_IDX_W-1:0] IFS_REG_SEP0 = 8'd0;
  localparam logic [IFS_CFG_IDX_W-1:0] IFS_REG_SEP1 = 8'd1;
  localparam logic [IFS_CFG_IDX_W-1:0] IFS_REG_SEP2 = 8'd2;
  localparam logic [IFS_CFG_IDX_W-1:0] IFS_REG_SEP3 = 8'd3;

  // Reset mask marks tab, newline and space.
  localparam logic [IFS_MASK_W-1:0] IFS_SEP0_RESET = 64'h0000_0001_0000_0600;

  localparam logic [7:0] IFS_CH_SPACE   = 8'h20;
  localparam logic [7:0] IFS_CH_TAB     = 8'h09;
  localparam logic [7:0] IFS_CH_NEWLINE = 8'h0A;

  // Queue between the classifier and the emitter.
  localparam int unsigned IFS_Q_DEPTH = 4;
  localparam int unsigned IFS_Q_PTR_W = $clog2(IFS_Q_DEPTH);
  localparam int unsigned IFS_Q_CNT_W = $clog2(IFS_Q_DEPTH + 1);

  typedef enum logic [1:0] {
    IFS_MODE_AWAIT = 2'd0,
    IFS_MODE_FIELD = 2'd1,
    IFS_MODE_WHITE = 2'd2
  } ifs_mode_t;

  typedef enum logic [1:0] {
    IFS_KIND_BYTE = 2'd0,
    IFS_KIND_EOF  = 2'd1,
    IFS_KIND_EOW  = 2'd2
  } ifs_kind_t;

  // One classified input byte: the results it causes, in output order.
  typedef struct packed {
    logic       has_byte;  // field byte
    logic       pre_eof;   // end of field caused by a delimiter
    logic [7:0] data;
    logic       post_eof;  // end of field closed by the end of word
    logic       eow;       // end of word
  } ifs_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ifs_q_stat_t;

endpackage

// File: hw/rtl/ifs_if.sv
// Channel interfaces of the IFS field splitter: input bytes, results, register writes.
// Depends on ifs_pkg for the register index and mask widths.
interface ifs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       split_ok;
  logic       last_of_word;

  modport source (output valid, data_byte, split_ok, last_of_word, input ready);
  modport sink (input valid, data_byte, split_ok, last_of_word, output ready);
endinterface

interface ifs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] out_byte;
  logic       last_result;

  modport source (output valid, item_kind, out_byte, last_result, input ready);
  modport sink (input valid, item_kind, out_byte, last_result, output ready);
endinterface

interface ifs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ifs_pkg::IFS_CFG_IDX_W-1:0]  reg_index;
  logic [ifs_pkg::IFS_MASK_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: hw/rtl/ifs_front.sv
// Classifier: holds the separator mask and the split mode, turns each input byte that
// causes results into one queue entry listing them. Depends on ifs_pkg and ifs_if.
module ifs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  ifs_in_if.sink               in_chan,
  ifs_cfg_if.sink              cfg_chan,
  input  ifs_pkg::ifs_q_stat_t q_stat,
  output logic                 push,
  output ifs_pkg::ifs_op_t     push_op
);

  logic [ifs_pkg::IFS_MASK_REGS-1:0][ifs_pkg::IFS_MASK_W-1:0] mask_r;
  ifs_pkg::ifs_mode_t mode_r, mode_nxt, mode_mid;
  logic accept, delim, white;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !q_stat.full;
  assign accept         = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= ifs_pkg::IFS_SEP0_RESET;
      mask_r[1] <= '0;
      mask_r[2] <= '0;
      mask_r[3] <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        ifs_pkg::IFS_REG_SEP0: mask_r[0] <= cfg_chan.wdata;
        ifs_pkg::IFS_REG_SEP1: mask_r[1] <= cfg_chan.wdata;
        ifs_pkg::IFS_REG_SEP2: mask_r[2] <= cfg_chan.wdata;
        ifs_pkg::IFS_REG_SEP3: mask_r[3] <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  assign delim = in_chan.split_ok &&
                 mask_r[in_chan.data_byte[7:6]][in_chan.data_byte[5:0]];
  assign white = delim && (in_chan.data_byte == ifs_pkg::IFS_CH_SPACE ||
                           in_chan.data_byte == ifs_pkg::IFS_CH_TAB ||
                           in_chan.data_byte == ifs_pkg::IFS_CH_NEWLINE);

  always_comb begin
    push_op          = '0;
    push_op.data     = in_chan.data_byte;
    mode_mid         = mode_r;
    if (!delim) begin
      push_op.has_byte = 1'b1;
      mode_mid         = ifs_pkg::IFS_MODE_FIELD;
    end else if (white) begin
      if (mode_r == ifs_pkg::IFS_MODE_FIELD) begin
        push_op.pre_eof = 1'b1;
        mode_mid        = ifs_pkg::IFS_MODE_WHITE;
      end
    end else begin
      // A non-white delimiter after white is absorbed; otherwise it closes a field,
      // possibly an empty one.
      push_op.pre_eof = (mode_r != ifs_pkg::IFS_MODE_WHITE);
      mode_mid        = ifs_pkg::IFS_MODE_AWAIT;
    end

    mode_nxt = mode_mid;
    if (in_chan.last_of_word) begin
      push_op.post_eof = (mode_mid == ifs_pkg::IFS_MODE_FIELD);
      push_op.eow      = 1'b1;
      mode_nxt         = ifs_pkg::IFS_MODE_AWAIT;
    end
  end

  // Bytes that cause no result never enter the queue.
  assign push = accept && (push_op.has_byte || push_op.pre_eof ||
                           push_op.post_eof || push_op.eow);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ifs_pkg::IFS_MODE_AWAIT;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

`ifndef SYNTH
  a_word_end_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.last_of_word |=> mode_r == ifs_pkg::IFS_MODE_AWAIT)
    else $error("split mode not cleared after end of word");

  a_leading_white_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && white && mode_r != ifs_pkg::IFS_MODE_FIELD && !in_chan.last_of_word
    |-> !push)
    else $error("white delimiter outside a field produced a result");
`endif

endmodule

// File: hw/rtl/ifs_queue.sv
// Small first-in first-out queue of classified entries between front and back.
// Depends on ifs_pkg for the entry type and depth.
module ifs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ifs_pkg::ifs_op_t     push_op,
  input  logic                 pop,
  output ifs_pkg::ifs_op_t     head,
  output ifs_pkg::ifs_q_stat_t stat
);

  ifs_pkg::ifs_op_t mem_r [ifs_pkg::IFS_Q_DEPTH];
  logic [ifs_pkg::IFS_Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [ifs_pkg::IFS_Q_CNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == ifs_pkg::IFS_Q_CNT_W'(ifs_pkg::IFS_Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ifs_pkg::IFS_Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ifs_pkg::IFS_Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + ifs_pkg::IFS_Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - ifs_pkg::IFS_Q_CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue popped while empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !stat.full)
    else $error("queue pushed while full");
`endif

endmodule

// File: hw/rtl/ifs_back.sv
// Emitter: walks the results of the head queue entry into an output register, one
// result word per cycle while the output is not stalled. Depends on ifs_pkg and ifs_if.
module ifs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ifs_pkg::ifs_op_t     head,
  input  ifs_pkg::ifs_q_stat_t q_stat,
  output logic                 pop,
  ifs_out_if.source            out_chan
);

  // Slot 0 is the field byte or delimiter end of field, slot 1 the closing end
  // of field, slot 2 the end of word.
  logic [2:0] done_r, done_nxt, pending;
  logic       load;
  logic       out_valid_r, out_last_r, out_last_nxt;
  ifs_pkg::ifs_kind_t out_kind_r, out_kind_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  assign pending = {head.eow, head.post_eof, head.has_byte || head.pre_eof} & ~done_r;
  assign load    = !q_stat.empty && (!out_valid_r || out_chan.ready);

  always_comb begin
    out_byte_nxt = '0;
    done_nxt     = done_r;
    if (pending[0]) begin
      out_kind_nxt = head.has_byte ? ifs_pkg::IFS_KIND_BYTE : ifs_pkg::IFS_KIND_EOF;
      out_byte_nxt = head.has_byte ? head.data : 8'h00;
      out_last_nxt = !(pending[1] || pending[2]);
      done_nxt[0]  = 1'b1;
    end else if (pending[1]) begin
      out_kind_nxt = ifs_pkg::IFS_KIND_EOF;
      out_last_nxt = !pending[2];
      done_nxt[1]  = 1'b1;
    end else begin
      out_kind_nxt = ifs_pkg::IFS_KIND_EOW;
      out_last_nxt = 1'b1;
      done_nxt[2]  = 1'b1;
    end
  end

  assign pop = load && out_last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r <= out_last_nxt ? 3'b000 : done_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.item_kind   = out_kind_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.last_result = out_last_r;

`ifndef SYNTH
  a_partial_entry_kept: assert property (@(posedge clk) disable iff (!rst_n)
    done_r != 3'b000 |-> !q_stat.empty)
    else $error("partly emitted entry left the queue");

  a_eow_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == ifs_pkg::IFS_KIND_EOW |-> out_last_r)
    else $error("end of word not marked as last result");
`endif

endmodule

// File: hw/rtl/ifs_field_splitter_core.sv
// Top level of the IFS field splitter: classifier, entry queue and emitter.
// Depends on ifs_pkg, ifs_if, ifs_front, ifs_queue and ifs_back.
//
//   channel   direction  payload                                handshake
//   in_chan   sink       data_byte, split_ok, last_of_word      valid/ready
//   out_chan  source     item_kind, out_byte, last_result       valid/ready
//   cfg_chan  sink       reg_index, wdata (sep_mask_0..3)       valid/ready, always ready
//
// One input byte is accepted per cycle while the four-entry queue has room.
// Each byte yields zero to three result words; the emitter sends one per cycle while
// out_chan is not stalled, so sustained input rate is bounded by results per byte.
// The first result of a byte passes the queue and the output register before it is presented.
// Reset is synchronous and active low; it empties the queue, returns the mode to
// awaiting field and sets the mask back to tab, newline and space.
// Input and output stall independently; the queue absorbs the difference.
module ifs_field_splitter_core (
  input  logic       clk,
  input  logic       rst_n,
  ifs_in_if.sink     in_chan,
  ifs_out_if.source  out_chan,
  ifs_cfg_if.sink    cfg_chan
);

  logic                 push, pop;
  ifs_pkg::ifs_op_t     push_op, head;
  ifs_pkg::ifs_q_stat_t q_stat;

  ifs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_op  (push_op)
  );

  ifs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  ifs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
